// ===== src/ktt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktt_pkg
// shared types and constants of the keyed timer table
// ----------------------------------------------------------------------------
package ktt_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int MAX_FIRE  = 16;
    localparam logic [6:0] PCT_FULL = 7'd100;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;
    localparam logic [1:0] KIND_TICK   = 2'd3;

    localparam logic [2:0] RES_ACCEPT = 3'd0;
    localparam logic [2:0] RES_REJECT = 3'd1;
    localparam logic [2:0] RES_QUERY  = 3'd2;
    localparam logic [2:0] RES_FIRED  = 3'd3;
    localparam logic [2:0] RES_TICK   = 3'd4;

    typedef enum logic [2:0] {
        CELL_NOP,
        CELL_CANCEL,
        CELL_LOAD,
        CELL_SHIFT,
        CELL_APPLY
    } cell_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_INS,
        ST_DIV,
        ST_RANK,
        ST_APPLY,
        ST_EMIT,
        ST_RESP
    } state_t;

    typedef struct packed {
        cell_op_t     op;
        logic [31:0]  key;
        logic [7:0]   typ;
        logic [23:0]  es;
        logic [23:0]  lim;
        logic [23:0]  hold;
        logic [15:0]  tick;
    } ctrl_t;

endpackage

// ===== src/ktt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktt_cell
// one timer entry of the chain, with insert token and rotating key probe
// ----------------------------------------------------------------------------
module ktt_cell #(
    parameter int RW = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ktt_pkg::ctrl_t   ctrl,
    input  logic             tok_in,
    output logic             tok_out,
    input  logic [31:0]      probe_key_in,
    input  logic             probe_cand_in,
    output logic [31:0]      probe_key_out,
    output logic             probe_cand_out,
    output logic             valid,
    output logic             match,
    output logic             took,
    output logic             emit,
    output logic [RW-1:0]    rank,
    output logic [31:0]      key_o,
    output logic [7:0]       typ_o,
    output logic [23:0]      el_o,
    output logic [23:0]      lim_o
);

    logic               valid_reg, tok_reg, emit_reg, probe_cand_reg;
    logic [31:0]        key_reg, probe_key_reg;
    logic [7:0]         typ_reg;
    logic [23:0]        el_reg, lim_reg;
    logic signed [24:0] hold_reg, hold_dec;
    logic               fired_reg;
    logic [RW-1:0]      rank_reg;
    logic [24:0]        sum;
    logic               cand, win;

    assign sum      = {1'b0, el_reg} + 25'(ctrl.tick);
    assign cand     = valid_reg && (sum >= {1'b0, lim_reg}) && !fired_reg;
    assign win      = cand && (8'(rank_reg) < 8'(ktt_pkg::MAX_FIRE));
    assign hold_dec = hold_reg - $signed({9'd0, ctrl.tick});
    assign took     = tok_in && !valid_reg;
    assign match    = valid_reg && (key_reg == ctrl.key);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= 1'b0;
            emit_reg  <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_in && valid_reg;
            if (took)
                valid_reg <= 1'b1;
            case (ctrl.op)
                ktt_pkg::CELL_CANCEL:
                begin
                    if (match)
                        valid_reg <= 1'b0;
                end
                ktt_pkg::CELL_LOAD:
                    emit_reg <= 1'b0;
                ktt_pkg::CELL_APPLY:
                begin
                    emit_reg <= win;
                    // freed once hold runs out after firing
                    if (valid_reg && sum >= {1'b0, lim_reg} && fired_reg && hold_dec <= 0)
                        valid_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (took)
        begin
            key_reg   <= ctrl.key;
            typ_reg   <= ctrl.typ;
            el_reg    <= ctrl.es;
            lim_reg   <= ctrl.lim;
            hold_reg  <= $signed({1'b0, ctrl.hold});
            fired_reg <= 1'b0;
        end
        case (ctrl.op)
            ktt_pkg::CELL_LOAD:
            begin
                probe_key_reg  <= key_reg;
                probe_cand_reg <= cand;
                rank_reg       <= '0;
            end
            ktt_pkg::CELL_SHIFT:
            begin
                probe_key_reg  <= probe_key_in;
                probe_cand_reg <= probe_cand_in;
                if (probe_cand_in && probe_key_in < key_reg)
                    rank_reg <= rank_reg + RW'(1);
            end
            ktt_pkg::CELL_APPLY:
            begin
                if (valid_reg)
                begin
                    if (sum < {1'b0, lim_reg})
                        el_reg <= sum[23:0];
                    else
                    begin
                        el_reg <= lim_reg;
                        if (!fired_reg)
                        begin
                            if (win)
                                fired_reg <= 1'b1;
                        end
                        else
                            hold_reg <= hold_dec;
                    end
                end
            end
            default: ;
        endcase
    end

    assign tok_out        = tok_reg;
    assign probe_key_out  = probe_key_reg;
    assign probe_cand_out = probe_cand_reg;
    assign valid          = valid_reg;
    assign emit           = emit_reg;
    assign rank           = rank_reg;
    assign key_o          = key_reg;
    assign typ_o          = typ_reg;
    assign el_o           = el_reg;
    assign lim_o          = lim_reg;

endmodule

// ===== src/keyed_timer_table_fire_then_hold.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_timer_table_fire_then_hold
// table of keyed one-shot timers held in a ring of entry cells
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_ready, results leave on out_valid/out_ready
// through one output register. One request is worked at a time; in_ready is
// high only when the block is idle.
// Cancel and rejected requests pass the decode and response states; an insert
// walks a token through the cells to the lowest free entry, and a query that
// divides the percentage runs a restoring division, one quotient bit per cycle
// over 7 bits. A tick rotates every key once around the ring to rank the
// firing entries by key, then the apply step updates all entries, then one
// result per cycle is sent while the receiver takes it, at most 16 fire
// results or one tick-done result. When the receiver stalls, the output
// register holds its result and the block waits. Reset empties the table at
// once; no clearing pass.
// ----------------------------------------------------------------------------
module keyed_timer_table_fire_then_hold #(
    parameter int DEPTH = ktt_pkg::DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [31:0] key,
    input  logic [7:0]  entry_type,
    input  logic [23:0] elapsed_start,
    input  logic [23:0] limit_time,
    input  logic [23:0] hold_time,
    input  logic [15:0] tick_amount,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  result_kind,
    output logic [31:0] result_key,
    output logic [7:0]  result_type,
    output logic [6:0]  progress_percent,
    output logic        last
);

    localparam int RW = $clog2(DEPTH) + 1;
    localparam int CW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    ktt_pkg::state_t   state_reg, state_next;
    ktt_pkg::ctrl_t    ctrl;
    ktt_pkg::cell_op_t cell_op;

    logic [1:0]  kind_reg;
    logic [31:0] key_reg;
    logic [7:0]  typ_reg;
    logic [23:0] es_reg, lim_reg, hold_reg;
    logic [15:0] tick_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [4:0]  r_reg, r_next;
    logic [30:0] num_reg, num_next;
    logic [23:0] den_reg, den_next;
    logic [6:0]  q_reg, q_next;
    logic [2:0]  bit_reg, bit_next;
    logic [2:0]  resp_kind_reg, resp_kind_next;
    logic [6:0]  resp_pct_reg, resp_pct_next;

    logic        out_valid_reg;
    logic [2:0]  out_kind_reg;
    logic [31:0] out_key_reg;
    logic [7:0]  out_type_reg;
    logic [6:0]  out_pct_reg;
    logic        out_last_reg;

    logic        res_valid, slot_free, tok_start;
    logic [2:0]  res_kind;
    logic [31:0] res_key;
    logic [7:0]  res_type;
    logic [6:0]  res_pct;
    logic        res_last;

    logic [DEPTH-1:0]  c_valid, c_match, c_took, c_emit, c_tok, c_pcand;
    logic [RW-1:0]     c_rank [DEPTH];
    logic [31:0]       c_key [DEPTH];
    logic [31:0]       c_pkey [DEPTH];
    logic [7:0]        c_typ [DEPTH];
    logic [23:0]       c_el [DEPTH];
    logic [23:0]       c_lim [DEPTH];

    logic        found, full, hit, more;
    logic [23:0] sel_el, sel_lim;
    logic [31:0] hit_key;
    logic [7:0]  hit_typ;
    logic [30:0] trial;

    assign ctrl.op   = cell_op;
    assign ctrl.key  = key_reg;
    assign ctrl.typ  = typ_reg;
    assign ctrl.es   = es_reg;
    assign ctrl.lim  = lim_reg;
    assign ctrl.hold = hold_reg;
    assign ctrl.tick = tick_reg;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            ktt_cell #(.RW(RW)) u_cell (
                .clk            (clk),
                .rst_n          (rst_n),
                .ctrl           (ctrl),
                .tok_in         ((gi == 0) ? tok_start : c_tok[(gi + DEPTH - 1) % DEPTH]),
                .tok_out        (c_tok[gi]),
                .probe_key_in   (c_pkey[(gi + DEPTH - 1) % DEPTH]),
                .probe_cand_in  (c_pcand[(gi + DEPTH - 1) % DEPTH]),
                .probe_key_out  (c_pkey[gi]),
                .probe_cand_out (c_pcand[gi]),
                .valid          (c_valid[gi]),
                .match          (c_match[gi]),
                .took           (c_took[gi]),
                .emit           (c_emit[gi]),
                .rank           (c_rank[gi]),
                .key_o          (c_key[gi]),
                .typ_o          (c_typ[gi]),
                .el_o           (c_el[gi]),
                .lim_o          (c_lim[gi])
            );
        end
    endgenerate

    // one-hot selects over the cells
    always_comb
    begin
        sel_el  = '0;
        sel_lim = '0;
        hit_key = '0;
        hit_typ = '0;
        hit     = 1'b0;
        more    = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (c_match[i])
            begin
                sel_el  = sel_el | c_el[i];
                sel_lim = sel_lim | c_lim[i];
            end
            if (c_emit[i] && 8'(c_rank[i]) == 8'(r_reg))
            begin
                hit     = 1'b1;
                hit_key = hit_key | c_key[i];
                hit_typ = hit_typ | c_typ[i];
            end
            if (c_emit[i] && 8'(c_rank[i]) == 8'(r_reg) + 8'd1)
                more = 1'b1;
        end
    end

    assign found     = |c_match;
    assign full      = &c_valid;
    assign slot_free = !out_valid_reg || out_ready;
    assign trial     = 31'(den_reg) << bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ktt_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cell_op        = ktt_pkg::CELL_NOP;
        tok_start      = 1'b0;
        cnt_next       = cnt_reg;
        r_next         = r_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        q_next         = q_reg;
        bit_next       = bit_reg;
        resp_kind_next = resp_kind_reg;
        resp_pct_next  = resp_pct_reg;
        res_valid      = 1'b0;
        res_kind       = resp_kind_reg;
        res_key        = key_reg;
        res_type       = '0;
        res_pct        = resp_pct_reg;
        res_last       = 1'b1;
        in_ready       = 1'b0;
        case (state_reg)
            ktt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    state_next = ktt_pkg::ST_DECODE;
            end
            ktt_pkg::ST_DECODE:
            begin
                resp_pct_next  = '0;
                resp_kind_next = ktt_pkg::RES_REJECT;
                state_next     = ktt_pkg::ST_RESP;
                case (kind_reg)
                    ktt_pkg::KIND_INSERT:
                    begin
                        if (!found && !full)
                        begin
                            tok_start = 1'b1;
                            // the first cell may take the token at once
                            if (|c_took)
                                resp_kind_next = ktt_pkg::RES_ACCEPT;
                            else
                                state_next = ktt_pkg::ST_INS;
                        end
                    end
                    ktt_pkg::KIND_CANCEL:
                    begin
                        cell_op = ktt_pkg::CELL_CANCEL;
                        if (found)
                            resp_kind_next = ktt_pkg::RES_ACCEPT;
                    end
                    ktt_pkg::KIND_QUERY:
                    begin
                        if (found)
                        begin
                            resp_kind_next = ktt_pkg::RES_QUERY;
                            if (sel_lim == '0 || sel_el >= sel_lim)
                                resp_pct_next = ktt_pkg::PCT_FULL;
                            else
                            begin
                                num_next   = 31'(sel_el * 7'd100);
                                den_next   = sel_lim;
                                q_next     = '0;
                                bit_next   = 3'd6;
                                state_next = ktt_pkg::ST_DIV;
                            end
                        end
                    end
                    default:
                    begin
                        cell_op    = ktt_pkg::CELL_LOAD;
                        cnt_next   = '0;
                        state_next = (DEPTH > 1) ? ktt_pkg::ST_RANK : ktt_pkg::ST_APPLY;
                    end
                endcase
            end
            ktt_pkg::ST_INS:
            begin
                if (|c_took)
                begin
                    resp_kind_next = ktt_pkg::RES_ACCEPT;
                    state_next     = ktt_pkg::ST_RESP;
                end
            end
            ktt_pkg::ST_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (num_reg >= trial)
                begin
                    num_next         = num_reg - trial;
                    q_next[bit_reg]  = 1'b1;
                end
                bit_next = bit_reg - 3'd1;
                if (bit_reg == 3'd0)
                begin
                    resp_pct_next = q_next;
                    state_next    = ktt_pkg::ST_RESP;
                end
            end
            ktt_pkg::ST_RANK:
            begin
                cell_op  = ktt_pkg::CELL_SHIFT;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(DEPTH - 2))
                    state_next = ktt_pkg::ST_APPLY;
            end
            ktt_pkg::ST_APPLY:
            begin
                cell_op    = ktt_pkg::CELL_APPLY;
                r_next     = '0;
                state_next = ktt_pkg::ST_EMIT;
            end
            ktt_pkg::ST_EMIT:
            begin
                res_valid = 1'b1;
                res_pct   = '0;
                if (hit)
                begin
                    res_kind = ktt_pkg::RES_FIRED;
                    res_key  = hit_key;
                    res_type = hit_typ;
                    res_last = !more;
                end
                else
                begin
                    res_kind = ktt_pkg::RES_TICK;
                    res_key  = '0;
                end
                if (slot_free)
                begin
                    r_next = r_reg + 5'd1;
                    if (!hit || !more)
                        state_next = ktt_pkg::ST_IDLE;
                end
            end
            ktt_pkg::ST_RESP:
            begin
                res_valid = 1'b1;
                if (slot_free)
                    state_next = ktt_pkg::ST_IDLE;
            end
            default:
                state_next = ktt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            kind_reg <= kind;
            key_reg  <= key;
            typ_reg  <= entry_type;
            es_reg   <= elapsed_start;
            lim_reg  <= limit_time;
            hold_reg <= hold_time;
            tick_reg <= tick_amount;
        end
        cnt_reg       <= cnt_next;
        r_reg         <= r_next;
        num_reg       <= num_next;
        den_reg       <= den_next;
        q_reg         <= q_next;
        bit_reg       <= bit_next;
        resp_kind_reg <= resp_kind_next;
        resp_pct_reg  <= resp_pct_next;
        if (res_valid && slot_free)
        begin
            out_kind_reg <= res_kind;
            out_key_reg  <= res_key;
            out_type_reg <= res_type;
            out_pct_reg  <= res_pct;
            out_last_reg <= res_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (slot_free)
            out_valid_reg <= res_valid;
    end

    assign out_valid        = out_valid_reg;
    assign result_kind      = out_kind_reg;
    assign result_key       = out_key_reg;
    assign result_type      = out_type_reg;
    assign progress_percent = out_pct_reg;
    assign last             = out_last_reg;

endmodule

// ===== verif/tb_keyed_timer_table_fire_then_hold.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_timer_table_fire_then_hold
// self-checking bench for the keyed timer table
// ----------------------------------------------------------------------------
// A behavioral copy of the table predicts every result of each accepted
// request; a checker compares each result in order, field by field. Directed
// cases cover full table, duplicates, zero limits, saturation and firing
// order, then random insert/tick/query/cancel mixes run under varied idling.
// ----------------------------------------------------------------------------
module tb_keyed_timer_table_fire_then_hold;

    localparam int NENT      = 16;
    localparam int WD_LIMIT  = 20000;
    localparam int STALL_LEN = 300;

    typedef struct packed {
        logic [2:0]  rkind;
        logic [31:0] rkey;
        logic [7:0]  rtype;
        logic [6:0]  pct;
        logic        fin;
    } timer_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  kind;
    logic [31:0] key;
    logic [7:0]  entry_type;
    logic [23:0] elapsed_start;
    logic [23:0] limit_time;
    logic [23:0] hold_time;
    logic [15:0] tick_amount;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  result_kind;
    logic [31:0] result_key;
    logic [7:0]  result_type;
    logic [6:0]  progress_percent;
    logic        last;

    // predicted table
    logic        tv[NENT];
    logic [31:0] tkey[NENT];
    logic [7:0]  ttype[NENT];
    logic [23:0] tel[NENT];
    logic [23:0] tlim[NENT];
    logic signed [25:0] thold[NENT];
    logic        tfired[NENT];

    timer_result_t pending_results[$];
    logic [31:0]   live_keys[$];
    int errors = 0;
    int send_idle_pct;
    int recv_idle_pct;
    int stall_cycles = 0;
    int stall_requests = 0;
    int stall_served = 0;
    int quiet_cycles = 0;

    keyed_timer_table_fire_then_hold dut (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int lookup(input logic [31:0] k);
        for (int i = 0; i < NENT; i++)
            if (tv[i] && tkey[i] == k)
                return i;
        return -1;
    endfunction

    function automatic void push_result(input logic [2:0] rk, input logic [31:0] k,
                                        input logic [7:0] t, input logic [6:0] p,
                                        input logic f);
        timer_result_t r;
        r.rkind = rk;
        r.rkey  = k;
        r.rtype = t;
        r.pct   = p;
        r.fin   = f;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_table(input logic [1:0] kd, input logic [31:0] k,
                                          input logic [7:0] t, input logic [23:0] es,
                                          input logic [23:0] lim, input logic [23:0] hd,
                                          input logic [15:0] tk);
        int idx;
        int fr;
        int ord[NENT];
        int cnt;
        int j;
        int nfire;
        logic [24:0] sum;
        logic [31:0] q;
        timer_result_t tail;
        fr = -1;
        cnt = 0;
        nfire = 0;
        idx = lookup(k);
        case (kd)
            ktt_pkg::KIND_INSERT:
            begin
                if (idx < 0)
                    for (int i = NENT - 1; i >= 0; i--)
                        if (!tv[i])
                            fr = i;
                if (fr < 0)
                    push_result(ktt_pkg::RES_REJECT, k, 8'd0, 7'd0, 1'b1);
                else
                begin
                    tv[fr] = 1'b1;
                    tkey[fr] = k;
                    ttype[fr] = t;
                    tel[fr] = es;
                    tlim[fr] = lim;
                    thold[fr] = {2'b00, hd};
                    tfired[fr] = 1'b0;
                    push_result(ktt_pkg::RES_ACCEPT, k, 8'd0, 7'd0, 1'b1);
                end
            end
            ktt_pkg::KIND_CANCEL:
            begin
                if (idx < 0)
                    push_result(ktt_pkg::RES_REJECT, k, 8'd0, 7'd0, 1'b1);
                else
                begin
                    tv[idx] = 1'b0;
                    push_result(ktt_pkg::RES_ACCEPT, k, 8'd0, 7'd0, 1'b1);
                end
            end
            ktt_pkg::KIND_QUERY:
            begin
                if (idx < 0)
                    push_result(ktt_pkg::RES_REJECT, k, 8'd0, 7'd0, 1'b1);
                else
                begin
                    if (tlim[idx] == 0 || tel[idx] >= tlim[idx])
                        q = 32'(ktt_pkg::PCT_FULL);
                    else
                        q = 32'((64'(tel[idx]) * 100) / tlim[idx]);
                    push_result(ktt_pkg::RES_QUERY, k, 8'd0, q[6:0], 1'b1);
                end
            end
            default:
            begin
                for (int i = 0; i < NENT; i++)
                    if (tv[i])
                    begin
                        j = cnt;
                        while (j > 0 && tkey[ord[j - 1]] > tkey[i])
                        begin
                            ord[j] = ord[j - 1];
                            j--;
                        end
                        ord[j] = i;
                        cnt++;
                    end
                for (int m = 0; m < cnt; m++)
                begin
                    int e;
                    e = ord[m];
                    sum = {1'b0, tel[e]} + tk;
                    if (sum < tlim[e])
                        tel[e] = sum[23:0];
                    else
                    begin
                        tel[e] = tlim[e];
                        if (!tfired[e])
                        begin
                            if (nfire < ktt_pkg::MAX_FIRE)
                            begin
                                push_result(ktt_pkg::RES_FIRED, tkey[e], ttype[e], 7'd0,
                                            1'b0);
                                nfire++;
                                tfired[e] = 1'b1;
                            end
                        end
                        else
                        begin
                            thold[e] = thold[e] - $signed({10'd0, tk});
                            if (thold[e] <= 0)
                                tv[e] = 1'b0;
                        end
                    end
                end
                if (nfire == 0)
                    push_result(ktt_pkg::RES_TICK, 32'd0, 8'd0, 7'd0, 1'b1);
                else
                begin
                    tail = pending_results.pop_back();
                    tail.fin = 1'b1;
                    pending_results.push_back(tail);
                end
            end
        endcase
    endfunction

    task automatic send_request(input logic [1:0] kd, input logic [31:0] k,
                                input logic [7:0] t, input logic [23:0] es,
                                input logic [23:0] lim, input logic [23:0] hd,
                                input logic [15:0] tk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        kind          <= kd;
        key           <= k;
        entry_type    <= t;
        elapsed_start <= es;
        limit_time    <= lim;
        hold_time     <= hd;
        tick_amount   <= tk;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_table(kd, k, t, es, lim, hd, tk);
        @(negedge clk);
    endtask

    task automatic do_insert(input logic [31:0] k, input logic [23:0] es,
                             input logic [23:0] lim, input logic [23:0] hd);
        send_request(ktt_pkg::KIND_INSERT, k, 8'($urandom), es, lim, hd, 16'($urandom));
    endtask

    task automatic do_tick(input logic [15:0] tk);
        send_request(ktt_pkg::KIND_TICK, $urandom, 8'($urandom), 24'($urandom),
                     24'($urandom), 24'($urandom), tk);
    endtask

    task automatic do_cmd(input logic [1:0] kd, input logic [31:0] k);
        send_request(kd, k, 8'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                     16'($urandom));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic clear_table();
        for (int i = 0; i < NENT; i++)
            if (tv[i])
                do_cmd(ktt_pkg::KIND_CANCEL, tkey[i]);
    endtask

    // full table, duplicate key, missing key, extreme fields
    task automatic test_table_limits();
        do_insert(32'hFFFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
        do_insert(32'hFFFF_FFFF, 24'd0, 24'd5, 24'd5);
        do_insert(32'h0, 24'd0, 24'd0, 24'd0);
        for (int i = 2; i < NENT; i++)
            do_insert(32'h100 + i, 24'd0, 24'd1000, 24'd10);
        do_insert(32'h5555_AAAA, 24'd0, 24'd1, 24'd1);
        do_cmd(ktt_pkg::KIND_QUERY, 32'hFFFF_FFFF);
        do_cmd(ktt_pkg::KIND_QUERY, 32'h0);
        do_cmd(ktt_pkg::KIND_QUERY, 32'hDEAD_BEEF);
        do_cmd(ktt_pkg::KIND_CANCEL, 32'hDEAD_BEEF);
        clear_table();
    endtask

    // saturation, percentages, firing order, hold countdown
    task automatic test_fire_hold();
        do_insert(32'h30, 24'd10, 24'd3, 24'd2);
        do_insert(32'h10, 24'd333, 24'd1000, 24'd0);
        do_insert(32'h20, 24'd7, 24'd9, 24'h80_0000);
        do_cmd(ktt_pkg::KIND_QUERY, 32'h30);
        do_cmd(ktt_pkg::KIND_QUERY, 32'h10);
        do_cmd(ktt_pkg::KIND_QUERY, 32'h20);
        do_tick(16'd0);
        do_tick(16'd700);
        do_tick(16'hFFFF);
        do_tick(16'd1);
        do_cmd(ktt_pkg::KIND_QUERY, 32'h20);
        clear_table();
    endtask

    // up to the fire limit: all sixteen entries fire on one tick
    task automatic test_mass_fire();
        for (int i = 0; i < NENT; i++)
            do_insert($urandom, 24'd0, 24'($urandom_range(5)), 24'($urandom_range(3)));
        do_tick(16'd10);
        do_tick(16'd1);
        do_tick(16'd2);
        clear_table();
    endtask

    task automatic test_random(input int n);
        int r;
        logic [31:0] k;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (live_keys.size() > 0 && $urandom_range(1))
                k = live_keys[$urandom_range(live_keys.size() - 1)];
            else
                k = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(40));
            if (r < 35)
            begin
                do_insert(k, 24'($urandom_range(50)),
                          ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(200)),
                          ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(100)));
                live_keys.push_back(k);
            end
            else if (r < 65)
                do_tick(($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(60)));
            else if (r < 85)
                do_cmd(ktt_pkg::KIND_QUERY, k);
            else
                do_cmd(ktt_pkg::KIND_CANCEL, k);
        end
    endtask

    // receiver stalls while requests keep coming
    task automatic test_backpressure();
        stall_requests++;
        for (int i = 0; i < 6; i++)
            do_insert(32'h900 + i, 24'd0, 24'd2, 24'd1);
        do_tick(16'd5);
        do_tick(16'd5);
    endtask

    // receiver side
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_served != stall_requests)
        begin
            out_ready <= 1'b0;
            stall_served <= stall_requests;
            stall_cycles <= STALL_LEN;
        end
        else if (stall_cycles > 0)
        begin
            out_ready <= 1'b0;
            stall_cycles <= stall_cycles - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result checker and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > WD_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result kind %0d key %h", $time, result_kind,
                             result_key);
                    errors++;
                end
                else
                begin
                    timer_result_t w;
                    w = pending_results.pop_front();
                    if (w.rkind !== result_kind || w.rkey !== result_key ||
                        w.rtype !== result_type || w.pct !== progress_percent ||
                        w.fin !== last)
                    begin
                        $display("%0t: mismatch exp kind %0d key %h type %h pct %0d last %0b",
                                 $time, w.rkind, w.rkey, w.rtype, w.pct, w.fin);
                        $display("%0t:          got kind %0d key %h type %h pct %0d last %0b",
                                 $time, result_kind, result_key, result_type,
                                 progress_percent, last);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        send_idle_pct = 22;
        recv_idle_pct = 50;
        for (int i = 0; i < NENT; i++)
        begin
            tv[i] = 1'b0;
            tfired[i] = 1'b0;
        end
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = ktt_pkg::KIND_TICK;
        key = '0;
        entry_type = '0;
        elapsed_start = '0;
        limit_time = '0;
        hold_time = '0;
        tick_amount = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        test_table_limits();
        test_fire_hold();
        test_mass_fire();
        test_random(10);
        send_idle_pct = 50;
        recv_idle_pct = 22;
        test_backpressure();
        test_random(10);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(10);
        wait_drained();
        if (errors == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
